### rtl/nnds_pkg.sv
// ----------------------------------------------------------------------------
// nnds_pkg
// Shared widths, register codes, result type and size clamping for the
// nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
package nnds_pkg;

    // Largest source dimension in pixels.
    localparam int MAX_DIM = 4096;

    // Widths fixed by the channel fields.
    localparam int PIX_W     = 32;
    localparam int COORD_W   = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 4;

    // Widths that follow from the largest dimension.
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int SIZE_W = CNT_W + 1;
    localparam int SUM_W  = 2 * CNT_W + 2;
    localparam int EXT_W  = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;

    // Result queue depth.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Reset value of every size register.
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    // Configuration register codes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = CFG_IDX_W'(0),
        CFG_SRC_HEIGHT = CFG_IDX_W'(1),
        CFG_DST_WIDTH  = CFG_IDX_W'(2),
        CFG_DST_HEIGHT = CFG_IDX_W'(3)
    } t_cfg_idx;

    // One result word as it travels from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic               frame_last;
    } t_result;

    // Source size: zero counts as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [SIZE_W-1:0] clamp_src(input logic [CFG_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (ext > EXT_W'(MAX_DIM)) begin
            return SIZE_W'(MAX_DIM);
        end
        return SIZE_W'(v);
    endfunction

    // Destination size: zero counts as one, anything above the source as the source.
    function automatic logic [SIZE_W-1:0] clamp_dst(input logic [CFG_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (ext > EXT_W'(hi)) begin
            return hi;
        end
        return SIZE_W'(v);
    endfunction

endpackage

### rtl/nnds_if.sv
// ----------------------------------------------------------------------------
// nnds channel interfaces
// Valid/ready channels for source pixels, result words and register writes.
// ----------------------------------------------------------------------------

// Source pixel channel.
interface nnds_in_if;
    logic                       valid;
    logic                       ready;
    logic [nnds_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// Result channel.
interface nnds_out_if;
    logic                         valid;
    logic                         ready;
    logic [nnds_pkg::PIX_W-1:0]   pixel_out;
    logic [nnds_pkg::COORD_W-1:0] dest_x;
    logic [nnds_pkg::COORD_W-1:0] dest_y;
    logic                         frame_last;

    modport source (output valid, output pixel_out, output dest_x, output dest_y,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input dest_x, input dest_y,
                    input frame_last, output ready);
endinterface

// Register write channel.
interface nnds_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [nnds_pkg::CFG_IDX_W-1:0] index;
    logic [nnds_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/nnds_front.sv
// ----------------------------------------------------------------------------
// nnds_front
// Holds the size registers and the raster counters, decides for each source
// word whether its column and row are kept, and pushes kept words to the queue.
// ----------------------------------------------------------------------------
module nnds_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nnds_in_if.sink           i_pix,
    nnds_cfg_if.sink          i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output nnds_pkg::t_result o_push_data
);

    // Size registers as written.
    logic [nnds_pkg::CFG_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;

    // Raster position and destination counters.
    logic [nnds_pkg::CNT_W-1:0] r_src_col, n_src_col, r_src_row, n_src_row;
    logic [nnds_pkg::CNT_W-1:0] r_dcol, n_dcol, r_drow, n_drow;

    // Running sums for the rounding window test.
    logic [nnds_pkg::SUM_W-1:0] r_col_tgt, n_col_tgt, r_col_base, n_col_base;
    logic [nnds_pkg::SUM_W-1:0] r_row_tgt, n_row_tgt, r_row_base, n_row_base;

    logic [nnds_pkg::SIZE_W-1:0] w_ws, w_hs, w_wd, w_hd;
    logic [nnds_pkg::SUM_W-1:0]  w_col_lim, w_row_lim;
    logic                        w_col_hit, w_row_hit, w_col_end, w_row_end;
    logic                        w_accept;

    // Effective sizes after clamping.
    assign w_ws = nnds_pkg::clamp_src(r_src_w);
    assign w_hs = nnds_pkg::clamp_src(r_src_h);
    assign w_wd = nnds_pkg::clamp_dst(r_dst_w, w_ws);
    assign w_hd = nnds_pkg::clamp_dst(r_dst_h, w_hs);

    // Keep tests: count below destination size and target inside the window.
    assign w_col_lim = r_col_base + nnds_pkg::SUM_W'({w_wd, 1'b0});
    assign w_row_lim = r_row_base + nnds_pkg::SUM_W'({w_hd, 1'b0});
    assign w_col_hit = (nnds_pkg::SIZE_W'(r_dcol) < w_wd) && (r_col_tgt >= r_col_base)
                       && (r_col_tgt < w_col_lim);
    assign w_row_hit = (nnds_pkg::SIZE_W'(r_drow) < w_hd) && (r_row_tgt >= r_row_base)
                       && (r_row_tgt < w_row_lim);

    // End of a source row and of the frame.
    assign w_col_end = (nnds_pkg::SIZE_W'(r_src_col) + nnds_pkg::SIZE_W'(1)) >= w_ws;
    assign w_row_end = (nnds_pkg::SIZE_W'(r_src_row) + nnds_pkg::SIZE_W'(1)) >= w_hs;

    // Handshakes.
    assign i_pix.ready = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_pix.valid && !i_q_full;

    // Result word for a kept pixel.
    assign o_push                 = w_accept && w_col_hit && w_row_hit;
    assign o_push_data.pixel_out  = i_pix.pixel_in;
    assign o_push_data.dest_x     = nnds_pkg::COORD_W'(r_dcol);
    assign o_push_data.dest_y     = nnds_pkg::COORD_W'(r_drow);
    assign o_push_data.frame_last =
        (nnds_pkg::SIZE_W'(r_dcol) == (w_wd - nnds_pkg::SIZE_W'(1))) &&
        (nnds_pkg::SIZE_W'(r_drow) == (w_hd - nnds_pkg::SIZE_W'(1)));

    // Next raster state for one accepted word.
    always_comb begin
        n_src_col  = r_src_col;
        n_src_row  = r_src_row;
        n_dcol     = r_dcol;
        n_drow     = r_drow;
        n_col_tgt  = r_col_tgt;
        n_col_base = r_col_base;
        n_row_tgt  = r_row_tgt;
        n_row_base = r_row_base;
        if (w_col_end) begin
            n_src_col  = '0;
            n_dcol     = '0;
            n_col_tgt  = nnds_pkg::SUM_W'(w_wd);
            n_col_base = '0;
            if (w_row_end) begin
                n_src_row  = '0;
                n_drow     = '0;
                n_row_tgt  = nnds_pkg::SUM_W'(w_hd);
                n_row_base = '0;
            end else begin
                n_src_row  = r_src_row + nnds_pkg::CNT_W'(1);
                n_row_base = w_row_lim;
                if (w_row_hit) begin
                    n_drow    = r_drow + nnds_pkg::CNT_W'(1);
                    n_row_tgt = r_row_tgt + nnds_pkg::SUM_W'({w_hs, 1'b0});
                end
            end
        end else begin
            n_src_col  = r_src_col + nnds_pkg::CNT_W'(1);
            n_col_base = w_col_lim;
            if (w_col_hit) begin
                n_dcol    = r_dcol + nnds_pkg::CNT_W'(1);
                n_col_tgt = r_col_tgt + nnds_pkg::SUM_W'({w_ws, 1'b0});
            end
        end
    end

    // Size registers and raster state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= nnds_pkg::CFG_RESET;
            r_src_h    <= nnds_pkg::CFG_RESET;
            r_dst_w    <= nnds_pkg::CFG_RESET;
            r_dst_h    <= nnds_pkg::CFG_RESET;
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_dcol     <= '0;
            r_drow     <= '0;
            r_col_tgt  <= nnds_pkg::SUM_W'(nnds_pkg::CFG_RESET);
            r_col_base <= '0;
            r_row_tgt  <= nnds_pkg::SUM_W'(nnds_pkg::CFG_RESET);
            r_row_base <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (nnds_pkg::t_cfg_idx'(i_cfg.index))
                    nnds_pkg::CFG_SRC_WIDTH:  r_src_w <= i_cfg.data;
                    nnds_pkg::CFG_SRC_HEIGHT: r_src_h <= i_cfg.data;
                    nnds_pkg::CFG_DST_WIDTH:  r_dst_w <= i_cfg.data;
                    nnds_pkg::CFG_DST_HEIGHT: r_dst_h <= i_cfg.data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_src_col  <= n_src_col;
                r_src_row  <= n_src_row;
                r_dcol     <= n_dcol;
                r_drow     <= n_drow;
                r_col_tgt  <= n_col_tgt;
                r_col_base <= n_col_base;
                r_row_tgt  <= n_row_tgt;
                r_row_base <= n_row_base;
            end
        end
    end

    // A word is never pushed into a full queue.
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("push into full queue");

    // At most one destination column per source column in a row.
    a_dcol_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcol <= r_src_col)
        else $error("destination column count ahead of source column");

    // At most one destination row per source row in a frame.
    a_drow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drow <= r_src_row)
        else $error("destination row count ahead of source row");

endmodule

### rtl/nnds_queue.sv
// ----------------------------------------------------------------------------
// nnds_queue
// Short first-in first-out queue of result words between the front and back.
// ----------------------------------------------------------------------------
module nnds_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nnds_pkg::t_result i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output nnds_pkg::t_result o_pop_data,
    output logic              o_empty
);

    nnds_pkg::t_result             r_entry [nnds_pkg::QUEUE_DEPTH];
    logic [nnds_pkg::QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [nnds_pkg::QPTR_W:0]     r_count, n_count;

    // Status and head entry.
    assign o_full     = (r_count == (nnds_pkg::QPTR_W + 1)'(nnds_pkg::QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_entry[r_rd_ptr];

    // Fill level.
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (nnds_pkg::QPTR_W + 1)'(1);
            2'b01:   n_count = r_count - (nnds_pkg::QPTR_W + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + nnds_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + nnds_pkg::QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    // Fill level never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (nnds_pkg::QPTR_W + 1)'(nnds_pkg::QUEUE_DEPTH))
        else $error("queue fill level above depth");

    // No pop from an empty queue.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    // Pointers stay apart by exactly the fill level.
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[nnds_pkg::QPTR_W-1:0])
        else $error("queue pointers disagree with fill level");

endmodule

### rtl/nnds_back.sv
// ----------------------------------------------------------------------------
// nnds_back
// Output register stage: takes words from the queue and presents them on the
// result channel, refilling in the same cycle a word is taken.
// ----------------------------------------------------------------------------
module nnds_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  nnds_pkg::t_result i_q_data,
    output logic              o_pop,
    nnds_out_if.source        o_res
);

    logic              r_valid;
    nnds_pkg::t_result r_data;

    // Load when the stage is empty or its word leaves this cycle.
    assign o_pop = !i_q_empty && (!r_valid || o_res.ready);

    assign o_res.valid      = r_valid;
    assign o_res.pixel_out  = r_data.pixel_out;
    assign o_res.dest_x     = r_data.dest_x;
    assign o_res.dest_y     = r_data.dest_y;
    assign o_res.frame_last = r_data.frame_last;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_data;
        end
    end

endmodule

### rtl/nearest_neighbor_downscaler_core.sv
// A kept source word goes through the result queue and then the output register to the result channel.
// Throughput: one source word per cycle while the result queue is not full.
// The four-entry result queue lets the pixel input keep running while results wait.
// Reset is synchronous and active low: sizes return to 1 and all counters to frame start.
// Reset needs no clearing pass; the block takes words as soon as reset is released.
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler_core
// Nearest-neighbor downscaler: keeps the source pixels whose column and row
// round to a destination coordinate and tags them with that coordinate.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nnds_in_if.sink     i_pix,
    nnds_cfg_if.sink    i_cfg,
    nnds_out_if.source  o_res
);

    logic              w_push, w_full, w_pop, w_empty;
    nnds_pkg::t_result w_push_data, w_pop_data;

    // Front: size registers, raster counters, keep decision.
    nnds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (i_cfg),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Queue between front and back.
    nnds_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    // Back: output register stage.
    nnds_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_data  (w_pop_data),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule

### tb/nearest_neighbor_downscaler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler_core_tb
// Self-checking bench for the downscaler. Raster pixel words are streamed
// under many slice and destination sizes with random handshake gaps. An
// integer model of the column and row selection predicts every kept word,
// and each result word is checked field by field.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler_core_tb;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int MAX_GAP       = 9;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_PRINTED   = 40;

    localparam logic [nnds_pkg::CFG_IDX_W-1:0] FIRST_SPARE_INDEX =
        nnds_pkg::CFG_IDX_W'(nnds_pkg::CFG_DST_HEIGHT) + 1'b1;
    localparam logic [nnds_pkg::CFG_IDX_W-1:0] LAST_SPARE_INDEX  = '1;
    localparam logic [nnds_pkg::CFG_W-1:0]     CFG_ALL_ONES      = '1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nnds_in_if  pix_bus();
    nnds_cfg_if cfg_bus();
    nnds_out_if res_bus();

    nearest_neighbor_downscaler_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Words waiting to be offered, and kept words still owed by the block.
    logic [nnds_pkg::PIX_W-1:0] source_words[$];
    nnds_pkg::t_result          kept_words[$];
    nnds_pkg::t_result          oldest_kept;

    // Handshake pacing, set by the stimulus between phases.
    int unsigned pix_gap_max    = MAX_GAP;
    int unsigned res_gap_max    = MAX_GAP;
    bit          hold_requested = 1'b0;
    int unsigned word_gap_left;
    int unsigned result_stall_left;
    int unsigned hold_left;

    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;

    // Shadow of the size registers and the selection state.
    logic [nnds_pkg::CFG_W-1:0] src_width_reg;
    logic [nnds_pkg::CFG_W-1:0] src_height_reg;
    logic [nnds_pkg::CFG_W-1:0] dst_width_reg;
    logic [nnds_pkg::CFG_W-1:0] dst_height_reg;
    int unsigned      src_col;
    int unsigned      src_row;
    int unsigned      dst_col;
    int unsigned      dst_row;
    longint unsigned  col_target;
    longint unsigned  col_base;
    longint unsigned  row_target;
    longint unsigned  row_base;

    // A size of zero counts as one; anything above the limit counts as the limit.
    function automatic int unsigned bounded_size(input int unsigned raw,
                                                 input int unsigned limit);
        if (raw == 0) begin
            return 1;
        end
        if (raw > limit) begin
            return limit;
        end
        return raw;
    endfunction

    function automatic void reset_scaler_state();
        src_width_reg  = nnds_pkg::CFG_RESET;
        src_height_reg = nnds_pkg::CFG_RESET;
        dst_width_reg  = nnds_pkg::CFG_RESET;
        dst_height_reg = nnds_pkg::CFG_RESET;
        src_col        = 0;
        src_row        = 0;
        dst_col        = 0;
        dst_row        = 0;
        col_target     = bounded_size(nnds_pkg::CFG_RESET,
                                      bounded_size(nnds_pkg::CFG_RESET, nnds_pkg::MAX_DIM));
        col_base       = 0;
        row_target     = bounded_size(nnds_pkg::CFG_RESET,
                                      bounded_size(nnds_pkg::CFG_RESET, nnds_pkg::MAX_DIM));
        row_base       = 0;
    endfunction

    // One source word: decide whether its column and row are kept, queue the
    // tagged word if both are, then advance the running sums.
    function automatic void downscale_word(input logic [nnds_pkg::PIX_W-1:0] word);
        int unsigned       ws;
        int unsigned       hs;
        int unsigned       wd;
        int unsigned       hd;
        bit                col_kept;
        bit                row_kept;
        nnds_pkg::t_result kept;
        ws = bounded_size(src_width_reg, nnds_pkg::MAX_DIM);
        hs = bounded_size(src_height_reg, nnds_pkg::MAX_DIM);
        wd = bounded_size(dst_width_reg, ws);
        hd = bounded_size(dst_height_reg, hs);
        col_kept = (dst_col < wd) && (col_target >= col_base) &&
                   (col_target < col_base + 2 * 64'(wd));
        row_kept = (dst_row < hd) && (row_target >= row_base) &&
                   (row_target < row_base + 2 * 64'(hd));

        if (col_kept && row_kept) begin
            kept.pixel_out  = word;
            kept.dest_x     = nnds_pkg::COORD_W'(dst_col);
            kept.dest_y     = nnds_pkg::COORD_W'(dst_row);
            kept.frame_last = (dst_col == wd - 1) && (dst_row == hd - 1);
            kept_words.push_back(kept);
        end

        if (col_kept) begin
            dst_col++;
            col_target += 2 * 64'(ws);
        end
        col_base += 2 * 64'(wd);

        // End of a source row; the last row also closes the frame.
        if (src_col + 1 >= ws) begin
            src_col    = 0;
            dst_col    = 0;
            col_target = wd;
            col_base   = 0;
            if (row_kept) begin
                dst_row++;
                row_target += 2 * 64'(hs);
            end
            row_base += 2 * 64'(hd);
            if (src_row + 1 >= hs) begin
                src_row    = 0;
                dst_row    = 0;
                row_target = hd;
                row_base   = 0;
            end else begin
                src_row++;
            end
        end else begin
            src_col++;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Destination size: mostly within the source, sometimes zero or too large.
    function automatic int unsigned pick_dst_size(input int unsigned src);
        case ($urandom_range(0, 9))
            0: begin
                return 0;
            end
            1: begin
                return $urandom_range(src, CFG_ALL_ONES);
            end
            default: begin
                return $urandom_range(1, src);
            end
        endcase
    endfunction

    task automatic queue_random_words(input int unsigned count);
        repeat (count) begin
            source_words.push_back($urandom);
        end
    endtask

    // Waits until every word is taken and every kept word has come back,
    // then lets the pipeline run dry.
    task automatic wait_drained();
        while (source_words.size() != 0 || pix_bus.valid || kept_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Called right after a falling edge; returns right after the accepting edge.
    task automatic write_register(input logic [nnds_pkg::CFG_IDX_W-1:0] index,
                                  input logic [nnds_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                             input int unsigned dw, input int unsigned dh,
                             input bit spare);
        wait_drained();
        write_register(nnds_pkg::CFG_SRC_WIDTH, nnds_pkg::CFG_W'(sw));
        write_register(nnds_pkg::CFG_SRC_HEIGHT, nnds_pkg::CFG_W'(sh));
        write_register(nnds_pkg::CFG_DST_WIDTH, nnds_pkg::CFG_W'(dw));
        write_register(nnds_pkg::CFG_DST_HEIGHT, nnds_pkg::CFG_W'(dh));
        if (spare) begin
            write_register(nnds_pkg::CFG_IDX_W'($urandom_range(FIRST_SPARE_INDEX,
                                                               LAST_SPARE_INDEX)),
                           nnds_pkg::CFG_W'($urandom));
        end
        @(negedge i_clk);
    endtask

    // Pixel driver: one word per handshake, with a drawn gap after each word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid    <= 1'b0;
            pix_bus.pixel_in <= '0;
            word_gap_left = 0;
        end else if (!pix_bus.valid || pix_bus.ready) begin
            if (word_gap_left > 0) begin
                word_gap_left--;
                pix_bus.valid <= 1'b0;
            end else if (source_words.size() > 0) begin
                pix_bus.valid    <= 1'b1;
                pix_bus.pixel_in <= source_words.pop_front();
                word_gap_left = $urandom_range(0, pix_gap_max);
            end else begin
                pix_bus.valid <= 1'b0;
            end
        end
    end

    // Result sink: a drawn stall after each result word, plus long holds on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            result_stall_left = 0;
            hold_left         = 0;
        end else begin
            if (hold_requested) begin
                hold_requested = 1'b0;
                hold_left      = HOLD_CYCLES;
            end
            if (res_bus.valid && res_bus.ready) begin
                result_stall_left = $urandom_range(0, res_gap_max);
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (result_stall_left > 0) begin
                result_stall_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // Monitor: tracks register writes, predicts from accepted pixel words and
    // checks each result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_scaler_state();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    nnds_pkg::CFG_SRC_WIDTH: begin
                        src_width_reg = cfg_bus.data;
                    end
                    nnds_pkg::CFG_SRC_HEIGHT: begin
                        src_height_reg = cfg_bus.data;
                    end
                    nnds_pkg::CFG_DST_WIDTH: begin
                        dst_width_reg = cfg_bus.data;
                    end
                    nnds_pkg::CFG_DST_HEIGHT: begin
                        dst_height_reg = cfg_bus.data;
                    end
                    default: begin
                    end
                endcase
            end
            if (pix_bus.valid && pix_bus.ready) begin
                downscale_word(pix_bus.pixel_in);
            end
            if (res_bus.valid && res_bus.ready) begin
                if (kept_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word 0x%08h at (%0d, %0d)",
                                              res_bus.pixel_out, res_bus.dest_x,
                                              res_bus.dest_y));
                end else begin
                    oldest_kept = kept_words.pop_front();
                    if (res_bus.pixel_out !== oldest_kept.pixel_out) begin
                        report_mismatch($sformatf("pixel_out 0x%08h, expected 0x%08h",
                                                  res_bus.pixel_out, oldest_kept.pixel_out));
                    end
                    if (res_bus.dest_x !== oldest_kept.dest_x) begin
                        report_mismatch($sformatf("dest_x %0d, expected %0d",
                                                  res_bus.dest_x, oldest_kept.dest_x));
                    end
                    if (res_bus.dest_y !== oldest_kept.dest_y) begin
                        report_mismatch($sformatf("dest_y %0d, expected %0d",
                                                  res_bus.dest_y, oldest_kept.dest_y));
                    end
                    if (res_bus.frame_last !== oldest_kept.frame_last) begin
                        report_mismatch($sformatf("frame_last %0b, expected %0b",
                                                  res_bus.frame_last, oldest_kept.frame_last));
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_bus.valid && pix_bus.ready) ||
            (res_bus.valid && res_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("nearest_neighbor_downscaler_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed cases first, then random phases of frames and noise.
    initial begin
        int unsigned random_items;
        int unsigned phase;
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        int unsigned count;

        pix_bus.valid    = 1'b0;
        pix_bus.pixel_in = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = '0;
        cfg_bus.data     = '0;
        res_bus.ready    = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset sizes are 1x1: every word is kept and closes a frame.
        source_words.push_back('0);
        source_words.push_back('1);

        // 5x2 down to 2x1: columns 0 and 3 (the half rounds up), row 1 dropped.
        set_sizes(5, 2, 2, 1, 1'b0);
        queue_random_words(10);

        // Zero sizes count as one.
        set_sizes(0, 0, 0, 0, 1'b0);
        queue_random_words(1);

        // A destination larger than the source is clamped to it.
        set_sizes(3, 1, CFG_ALL_ONES, CFG_ALL_ONES, 1'b0);
        queue_random_words(3);

        // Largest register values: source clamped to the maximum dimension.
        set_sizes(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, 1'b0);
        queue_random_words(6);

        // Shrink in mid-frame: the counters are already past the new row end.
        set_sizes(2, 2, 1, 1, 1'b0);
        queue_random_words(3);

        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            phase++;
            if (phase % 12 == 1) begin
                // Full-size frame with the sink held off while words keep coming.
                sw = $urandom_range(6, 12);
                sh = $urandom_range(3, 6);
                set_sizes(sw, sh, sw, sh, 1'b0);
                pix_gap_max    = 0;
                res_gap_max    = MAX_GAP;
                hold_requested = 1'b1;
                count          = sw * sh;
            end else if ($urandom_range(0, 99) < 85) begin
                // Whole frames, mostly small, now and then a wider slice.
                sw = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
                sh = $urandom_range(1, 8);
                dw = pick_dst_size(sw);
                dh = pick_dst_size(sh);
                set_sizes(sw, sh, dw, dh, 1'b0);
                pix_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
                res_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
                count       = $urandom_range(1, 3) * sw * sh;
            end else begin
                // Raw register values and a short, broken run of words.
                set_sizes($urandom_range(0, CFG_ALL_ONES), $urandom_range(0, CFG_ALL_ONES),
                          $urandom_range(0, CFG_ALL_ONES), $urandom_range(0, CFG_ALL_ONES),
                          1'b1);
                pix_gap_max = $urandom_range(0, MAX_GAP);
                res_gap_max = $urandom_range(0, MAX_GAP);
                count       = $urandom_range(1, 30);
            end
            // The last phase stops at the planned number of words.
            if (count > RANDOM_ITEMS - random_items) begin
                count = RANDOM_ITEMS - random_items;
            end
            queue_random_words(count);
            random_items += count;
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("nearest_neighbor_downscaler_core: match");
        end else begin
            $display("nearest_neighbor_downscaler_core: mismatch");
        end
        $finish;
    end

endmodule
